FILE: rtl/core/ble_pkg.sv
//------------------------------------------------------------------------------
// ble_pkg
// shared command and status codes for the bounded list engine
//------------------------------------------------------------------------------
package ble_pkg;

  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_INSERT   = 3'd1,
    CMD_DELETE   = 3'd2,
    CMD_SEARCH   = 3'd3,
    CMD_SORT     = 3'd4,
    CMD_EXTREMES = 3'd5,
    CMD_NOP6     = 3'd6,
    CMD_NOP7     = 3'd7
  } cmd_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // per-cycle operation broadcast from the sequencer to every cell
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_SORT   = 3'd3,
    OP_ROT    = 3'd4
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       asc;
    logic       even;
  } cell_ctl_t;

endpackage

FILE: rtl/core/bounded_list_engine_top.sv
//------------------------------------------------------------------------------
// bounded_list_engine_top
// packed signed list held in a chain of cells, driven by a command stream
//------------------------------------------------------------------------------
// usage:
//   in_* channel carries one command item; out_* channel returns one result
//   item per command. tdata fields are listed beside the ports.
// command behaviour (one item at a time):
//   clear, insert, delete: insert and delete shift all affected cells at once
//   search, extremes: the chain rotates one full turn past the compare
//     unit at cell 0
//   sort: odd-even transposition over LIST_DEPTH passes, each pass compares
//     every neighbor pair of its parity within the length in parallel
//   no new item is taken until the result item is accepted
// reset: rst_n low synchronously empties the list; entry contents are not
//   cleared, they are only read below the length
// stall: while out_tvalid is high and out_tready low the result holds and
//   in_tready stays low; the next item is taken once the result is gone
//------------------------------------------------------------------------------
module bounded_list_engine_top import ble_pkg::*; #(
  parameter int LIST_DEPTH = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // cmd[2:0], position[9:3], item_value[41:10], ascending[42]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata   // status[1:0], data_out[33:2], min_out[65:34],
                                   // found[66], found_index[72:67], count[79:73]
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int PW = (CW > 7) ? CW + 1 : 8;   // position vs length compare width

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t                       state_r;
  cmd_t                         cmd_r;
  logic [6:0]                   pos_r;
  logic signed [ELEM_WIDTH-1:0] key_r;
  logic                         asc_r;
  logic [CW-1:0]                cnt_r;
  logic [CW:0]                  step_r;    // rotation / sort pass counter
  logic [1:0]                   status_r;
  logic signed [ELEM_WIDTH-1:0] hi_r, lo_r, del_r;
  logic                         found_r;
  logic [IW-1:0]                fidx_r;
  logic                         out_valid_r;
  logic [79:0]                  out_data_r;
  logic [79:0]                  out_data_nxt;

  cell_ctl_t                    ctl;
  logic signed [ELEM_WIDTH-1:0] vals [LIST_DEPTH];
  logic signed [ELEM_WIDTH-1:0] key_in;
  logic [CW:0]                  pos_w;

  // input item value: sign-extend or truncate to element width
  always_comb begin
    logic signed [31:0] raw;
    raw = in_tdata[41:10];
    key_in = ELEM_WIDTH'(raw);
  end

  assign pos_w = (CW+1)'(pos_r);
  assign in_tready = (state_r == S_IDLE) && !out_valid_r;

  // cell control for the current cycle
  always_comb begin
    ctl.op   = OP_HOLD;
    ctl.asc  = asc_r;
    ctl.even = ~step_r[0];
    if (state_r == S_RUN) begin
      case (cmd_r)
        CMD_INSERT: if (status_r == ST_OK) ctl.op = OP_INSERT;
        CMD_DELETE: if (status_r == ST_OK) ctl.op = OP_DELETE;
        CMD_SORT:   ctl.op = OP_SORT;
        CMD_SEARCH, CMD_EXTREMES: ctl.op = OP_ROT;
        default:    ctl.op = OP_HOLD;
      endcase
    end
  end

  // chain of cells; rotation wraps slot 0 to the top
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic [CW:0] gi;
    logic        pair_lo, pair_hi;
    assign gi = (CW+1)'(g);
    // even pass pairs (0,1),(2,3)..; odd pass pairs (1,2),(3,4)..
    assign pair_lo = ((g % 2 == 0) == ctl.even) && (gi + 1'b1 < (CW+1)'(cnt_r));
    assign pair_hi = ((g % 2 == 1) == ctl.even) && (g > 0) && (gi < (CW+1)'(cnt_r));
    ble_cell #(.ELEM_WIDTH(ELEM_WIDTH)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .sel_ins   (gi == pos_w),
      .shift_up  (gi > pos_w),
      .shift_dn  (gi >= pos_w),
      .sort_lo   (pair_lo),
      .sort_hi   (pair_hi),
      .new_val   (key_r),
      .lower_val ((g == 0) ? vals[LIST_DEPTH-1] : vals[(g + LIST_DEPTH - 1) % LIST_DEPTH]),
      .upper_val ((g == LIST_DEPTH - 1) ? vals[0] : vals[(g + 1) % LIST_DEPTH]),
      .val       (vals[g])
    );
  end

  // result item fields; search index only goes out with a search
  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[1:0]   = status_r;
    out_data_nxt[79:73] = 7'(cnt_r);
    case (cmd_r)
      CMD_DELETE: out_data_nxt[33:2] = 32'(del_r);
      CMD_SEARCH: begin
        out_data_nxt[66]    = found_r;
        out_data_nxt[72:67] = 6'(fidx_r);
      end
      CMD_EXTREMES: if (status_r == ST_OK) begin
        out_data_nxt[33:2]  = 32'(hi_r);
        out_data_nxt[65:34] = 32'(lo_r);
      end
      default: ;
    endcase
  end

  // sequencer with result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            cmd_r    <= cmd_t'(in_tdata[2:0]);
            pos_r    <= in_tdata[9:3];
            key_r    <= key_in;
            asc_r    <= in_tdata[42];
            step_r   <= '0;
            found_r  <= 1'b0;
            fidx_r   <= '0;
            del_r    <= '0;
            status_r <= ST_OK;
            case (cmd_t'(in_tdata[2:0]))
              CMD_INSERT: begin
                if (cnt_r == CW'(LIST_DEPTH)) status_r <= ST_FULL;
                else if (PW'(in_tdata[9:3]) > PW'(cnt_r)) status_r <= ST_RANGE;
              end
              CMD_DELETE: begin
                if (cnt_r == '0) status_r <= ST_EMPTY;
                else if (PW'(in_tdata[9:3]) >= PW'(cnt_r)) status_r <= ST_RANGE;
              end
              CMD_EXTREMES: if (cnt_r == '0) status_r <= ST_EMPTY;
              default: ;
            endcase
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          case (cmd_r)
            CMD_CLEAR: begin
              cnt_r   <= '0;
              state_r <= S_DONE;
            end
            CMD_INSERT: begin
              if (status_r == ST_OK) cnt_r <= cnt_r + 1'b1;
              state_r <= S_DONE;
            end
            CMD_DELETE: begin
              if (status_r == ST_OK) begin
                del_r <= vals[pos_r[IW-1:0]];
                cnt_r <= cnt_r - 1'b1;
              end
              state_r <= S_DONE;
            end
            CMD_SORT: begin
              step_r <= step_r + 1'b1;
              if (step_r == (CW+1)'(LIST_DEPTH - 1)) state_r <= S_DONE;
            end
            CMD_SEARCH, CMD_EXTREMES: begin
              // cell 0 holds entry step_r during this cycle
              if (step_r < (CW+1)'(cnt_r)) begin
                if (!found_r && vals[0] == key_r) begin
                  found_r <= 1'b1;
                  fidx_r  <= step_r[IW-1:0];
                end
                if (step_r == '0 || vals[0] > hi_r) hi_r <= vals[0];
                if (step_r == '0 || vals[0] < lo_r) lo_r <= vals[0];
              end
              step_r <= step_r + 1'b1;
              if (step_r == (CW+1)'(LIST_DEPTH - 1)) state_r <= S_DONE;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_DONE: begin
          out_data_r  <= out_data_nxt;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/core/ble_cell.sv
//------------------------------------------------------------------------------
// ble_cell
// one list slot: holds a value and trades with its neighbors
//------------------------------------------------------------------------------
module ble_cell import ble_pkg::*; #(
  parameter int ELEM_WIDTH = 32
) (
  input  logic                         clk,
  input  cell_ctl_t                    ctl,
  input  logic                         sel_ins,     // this slot takes the new value
  input  logic                         shift_up,    // take lower neighbor value
  input  logic                         shift_dn,    // take upper neighbor value
  input  logic                         sort_lo,     // low slot of a compare pair
  input  logic                         sort_hi,     // high slot of a compare pair
  input  logic signed [ELEM_WIDTH-1:0] new_val,
  input  logic signed [ELEM_WIDTH-1:0] lower_val,
  input  logic signed [ELEM_WIDTH-1:0] upper_val,
  output logic signed [ELEM_WIDTH-1:0] val
);

  logic signed [ELEM_WIDTH-1:0] val_r, val_nxt;
  logic                         swap_lo, swap_hi;

  // swap when the pair is out of order
  assign swap_lo = ctl.asc ? (val_r > upper_val) : (val_r < upper_val);
  assign swap_hi = ctl.asc ? (lower_val > val_r) : (lower_val < val_r);

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      OP_INSERT: begin
        if (sel_ins) val_nxt = new_val;
        else if (shift_up) val_nxt = lower_val;
      end
      OP_DELETE: begin
        if (shift_dn) val_nxt = upper_val;
      end
      OP_SORT: begin
        if (sort_lo && swap_lo) val_nxt = upper_val;
        else if (sort_hi && swap_hi) val_nxt = lower_val;
      end
      OP_ROT: val_nxt = upper_val;
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule
